[rtl/hfr_pkg.sv]
// ----------------------------------------------------------------------------
// hfr_pkg
// Shared types and constants of the HID frame reassembler: frame layout,
// command codes, frame disposition, verdict and error codes, result record.
// ----------------------------------------------------------------------------
package hfr_pkg;

  // report layout
  localparam int unsigned INIT_DATA_START = 7;
  localparam int unsigned CONT_DATA_START = 5;
  localparam int unsigned POS_TYPE        = 4;
  localparam int unsigned POS_LEN_HI      = 5;
  localparam int unsigned POS_LEN_LO      = 6;
  localparam int unsigned TYPE_INIT_BIT   = 7;

  // channel that every device listens on
  localparam logic [31:0] CHAN_ALL = 32'hFFFF_FFFF;

  // known commands
  localparam logic [7:0] CMD_PING = 8'h81;
  localparam logic [7:0] CMD_MSG  = 8'h83;
  localparam logic [7:0] CMD_INIT = 8'h86;
  localparam logic [7:0] CMD_WINK = 8'h88;

  // reported length saturates here
  localparam logic [8:0] LEN_SAT = 9'h1FF;

  // how the current report is being handled
  typedef enum logic [5:0] {
    DISP_IGNORE     = 6'b000001,
    DISP_INIT_OK    = 6'b000010,
    DISP_INIT_QUIET = 6'b000100,
    DISP_CONT       = 6'b001000,
    DISP_SEQ_ERR    = 6'b010000,
    DISP_LEN_ERR    = 6'b100000
  } disp_e;

  typedef enum logic [1:0] {
    VERDICT_IGNORED  = 2'd0,
    VERDICT_WAITING  = 2'd1,
    VERDICT_COMPLETE = 2'd2,
    VERDICT_ERROR    = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LENGTH   = 2'd1,
    ERR_SEQUENCE = 2'd2,
    ERR_COMMAND  = 2'd3
  } error_e;

  // one result per report byte
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [8:0] payload_offset;
    logic       verdict_valid;
    verdict_e   verdict;
    error_e     error_code;
    logic [7:0] message_cmd;
    logic [8:0] message_len;
  } result_t;

  function automatic logic known_cmd(input logic [7:0] cmd);
    return (cmd == CMD_PING) || (cmd == CMD_MSG) || (cmd == CMD_INIT) || (cmd == CMD_WINK);
  endfunction

endpackage

[rtl/hid_frame_reassembler_unit.sv]
// ----------------------------------------------------------------------------
// hid_frame_reassembler_unit
// Rebuilds HID messages from 64-byte reports fed one byte per transfer.
// ----------------------------------------------------------------------------
// Takes one report byte per cycle while in_stall_o is low and gives exactly
// one result per byte: the input register and the result register are
// the only stages, with the header decode, bounds and sequence checks in
// between. Every result carries the payload byte and its buffer offset when
// the byte is stored, and the last byte of each report also carries the
// verdict (waiting, complete, error; with command and length) or ignored.
// channel_id lives at byte address 0 of the APB port and resets to all ones
// (broadcast mode); write it only while no report byte is in flight.
module hid_frame_reassembler_unit import hfr_pkg::*; #(
  parameter int unsigned REPORT_BYTES = 64,
  parameter int unsigned BUFFER_BYTES = 470
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // report bytes in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rpt_byte_i,
  // results out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [8:0]  payload_offset_o,
  output logic        verdict_valid_o,
  output logic [1:0]  verdict_o,
  output logic [1:0]  error_code_o,
  output logic [7:0]  message_cmd_o,
  output logic [8:0]  message_len_o
);

  localparam logic REG_CHANNEL_ID = 1'b0;

  logic [31:0] channel_id_q, channel_id_d;
  logic        cfg_write;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_ready;
  logic        step;
  result_t     res_comb;
  result_t     res_out;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CHANNEL_ID);
  assign prdata    = (paddr[2] == REG_CHANNEL_ID) ? channel_id_q : '0;

  always_comb begin
    channel_id_d = channel_id_q;
    if (cfg_write) begin
      channel_id_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_id_q <= CHAN_ALL;
    end else begin
      channel_id_q <= channel_id_d;
    end
  end

  // pipeline flow control
  assign step       = s1_valid && out_ready;
  assign in_stall_o = s1_valid && !out_ready;

  hfr_input_stage u_input_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .load_i     (!in_stall_o),
    .byte_i     (rpt_byte_i),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  hfr_frame_tracker #(
    .REPORT_BYTES (REPORT_BYTES),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_frame_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (s1_byte),
    .channel_id_i (channel_id_q),
    .result_o     (res_comb)
  );

  hfr_result_stage u_result_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .result_i    (res_comb),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .result_o    (res_out)
  );

  // result fields to ports
  assign payload_valid_o  = res_out.payload_valid;
  assign payload_byte_o   = res_out.payload_byte;
  assign payload_offset_o = res_out.payload_offset;
  assign verdict_valid_o  = res_out.verdict_valid;
  assign verdict_o        = res_out.verdict;
  assign error_code_o     = res_out.error_code;
  assign message_cmd_o    = res_out.message_cmd;
  assign message_len_o    = res_out.message_len;

endmodule

[rtl/hfr_input_stage.sv]
// ----------------------------------------------------------------------------
// hfr_input_stage
// Input register: captures one report byte per transfer.
// ----------------------------------------------------------------------------
module hfr_input_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       load_i,
  input  logic [7:0] byte_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;

  // load a new byte whenever the stage is free or drains this cycle
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (load_i) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        byte_d = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

[rtl/hfr_frame_tracker.sv]
// ----------------------------------------------------------------------------
// hfr_frame_tracker
// Per-report state: header capture, frame classification, bounds and
// sequence checks, payload offsets and the end-of-report verdict.
// ----------------------------------------------------------------------------
module hfr_frame_tracker import hfr_pkg::*; #(
  parameter int unsigned REPORT_BYTES = 64,
  parameter int unsigned BUFFER_BYTES = 470
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] channel_id_i,
  output result_t     result_o
);

  localparam int unsigned POS_W           = $clog2(REPORT_BYTES);
  localparam int unsigned WP_W            = $clog2(BUFFER_BYTES + REPORT_BYTES + 1);
  localparam int unsigned CW              = WP_W + 1;
  localparam int unsigned CONT_DATA_BYTES = REPORT_BYTES - CONT_DATA_START;
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(REPORT_BYTES - 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      chan_q, chan_d;
  disp_e            disp_q, disp_d;
  logic [7:0]       seq_q, seq_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [15:0]      len_q, len_d;
  logic [WP_W-1:0]  wp_q, wp_d;

  logic             match;
  logic             bcast;
  logic             no_room;
  logic             is_init;
  logic             store;
  logic [15:0]      new_len;
  logic [15:0]      wp_ext;
  logic [15:0]      wp_next_ext;
  result_t          res;

  always_comb begin
    pos_d  = pos_q;
    chan_d = chan_q;
    disp_d = disp_q;
    seq_d  = seq_q;
    cmd_d  = cmd_q;
    len_d  = len_q;
    wp_d   = wp_q;
    res    = '0;

    match   = (chan_q == CHAN_ALL) || (chan_q == channel_id_i);
    bcast   = (channel_id_i == CHAN_ALL);
    wp_ext  = 16'(wp_q);
    no_room = (wp_ext >= len_q) ||
              ((CW'(wp_q) + CW'(CONT_DATA_BYTES)) > CW'(BUFFER_BYTES));
    new_len = {len_q[15:8], byte_i};

    // header bytes
    if (pos_q < POS_W'(POS_TYPE)) begin
      chan_d = (pos_q == '0) ? {24'h0, byte_i} : {chan_q[23:0], byte_i};
    end else if (pos_q == POS_W'(POS_TYPE)) begin
      if (!match) begin
        disp_d = DISP_IGNORE;
      end else if (byte_i[TYPE_INIT_BIT]) begin
        seq_d  = '0;
        wp_d   = '0;
        cmd_d  = byte_i;
        len_d  = '0;
        disp_d = (bcast && byte_i != CMD_INIT) ? DISP_INIT_QUIET : DISP_INIT_OK;
      end else if (bcast || no_room) begin
        disp_d = DISP_IGNORE;
      end else if (byte_i == seq_q) begin
        seq_d  = seq_q + 8'd1;
        disp_d = DISP_CONT;
      end else begin
        disp_d = DISP_SEQ_ERR;
      end
    end else if (pos_q == POS_W'(POS_LEN_HI)) begin
      if (disp_q == DISP_INIT_OK || disp_q == DISP_INIT_QUIET) begin
        len_d = {byte_i, 8'h00};
      end
    end else if (pos_q == POS_W'(POS_LEN_LO)) begin
      if (disp_q == DISP_INIT_OK || disp_q == DISP_INIT_QUIET) begin
        if (disp_q == DISP_INIT_OK && new_len > 16'(BUFFER_BYTES)) begin
          len_d  = '0;
          disp_d = DISP_LEN_ERR;
        end else begin
          len_d = new_len;
        end
      end
    end

    // payload bytes go to the buffer
    is_init = (disp_q == DISP_INIT_OK) || (disp_q == DISP_INIT_QUIET) ||
              (disp_q == DISP_LEN_ERR);
    store   = (is_init && pos_q >= POS_W'(INIT_DATA_START)) ||
              (disp_q == DISP_CONT && pos_q >= POS_W'(CONT_DATA_START));
    if (store) begin
      wp_d               = wp_q + 1'b1;
      res.payload_valid  = 1'b1;
      res.payload_byte   = byte_i;
      res.payload_offset = wp_ext[8:0];
    end
    wp_next_ext = 16'(wp_d);

    // verdict on the last byte of the report
    if (pos_q == LAST_POS) begin
      res.verdict_valid = 1'b1;
      if (disp_q == DISP_SEQ_ERR) begin
        res.verdict    = VERDICT_ERROR;
        res.error_code = ERR_SEQUENCE;
      end else if (disp_q == DISP_LEN_ERR) begin
        res.verdict    = VERDICT_ERROR;
        res.error_code = ERR_LENGTH;
      end else if (disp_q == DISP_INIT_OK || disp_q == DISP_CONT) begin
        if (wp_next_ext < len_q) begin
          res.verdict = VERDICT_WAITING;
        end else if (known_cmd(cmd_q)) begin
          res.verdict = VERDICT_COMPLETE;
        end else begin
          res.verdict    = VERDICT_ERROR;
          res.error_code = ERR_COMMAND;
        end
      end
      if (res.verdict != VERDICT_IGNORED) begin
        res.message_cmd = cmd_q;
        res.message_len = (len_q > 16'(LEN_SAT)) ? LEN_SAT : len_q[8:0];
      end
    end

    pos_d = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      chan_q <= '0;
      disp_q <= DISP_IGNORE;
      seq_q  <= '0;
      cmd_q  <= '0;
      len_q  <= '0;
      wp_q   <= '0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      chan_q <= chan_d;
      disp_q <= disp_d;
      seq_q  <= seq_d;
      cmd_q  <= cmd_d;
      len_q  <= len_d;
      wp_q   <= wp_d;
    end
  end

  assign result_o = res;

endmodule

[rtl/hfr_result_stage.sv]
// ----------------------------------------------------------------------------
// hfr_result_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hfr_result_stage import hfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    ready_o,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q, result_d;

  // free when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d  = valid_q;
    result_d = result_q;
    if (ready_o) begin
      valid_d  = valid_i;
      result_d = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hid_frame_reassembler_unit. A scripted set of
// reports walks the header cases (broadcast and assigned channel, init and
// continuation frames, length, sequence and command errors, buffer bounds,
// length saturation). Random reports follow: mostly well-formed messages
// with random content, plus wrong sequences, foreign channels and raw noise.
// Every accepted byte runs through a cycle-free model of the reassembler,
// and each result transfer is compared with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb import hfr_pkg::*;;

  localparam int REPORT_BYTES    = 64;
  localparam int BUF_BYTES       = 470;
  localparam int INIT_DATA_BYTES = REPORT_BYTES - INIT_DATA_START;
  localparam int CONT_BYTES      = REPORT_BYTES - CONT_DATA_START;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_CYCLES     = 400;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int MAX_REPORTED    = 10;
  localparam int RANDOM_PHASES   = 5;
  localparam int REPORTS_PER_PHASE = 1;

  localparam logic [2:0]  ADDR_CHANNEL_ID = 3'd0;
  localparam logic [31:0] ID_A = 32'h1234_5678;
  localparam logic [31:0] ID_B = 32'h1234_5679;
  localparam logic [31:0] ID_NEAR_ALL = 32'hFFFF_FFFE;

  // one scripted report row; cont rows step the sequence number per repeat
  typedef struct packed {
    bit          set_id;
    logic [31:0] id;
    logic [31:0] chan;
    bit          init;
    logic [7:0]  kind;
    logic [15:0] len;
    logic [3:0]  reps;
    bit          typed;
    verdict_e    vd;
    error_e      ec;
  } script_row_t;

  // one report byte waiting to be sent, with an optional typed verdict
  typedef struct packed {
    logic [7:0] data;
    bit         typed;
    verdict_e   vd;
    error_e     ec;
  } report_byte_t;

  localparam script_row_t SCRIPT [20] = '{
    '{1'b0, 32'h0,    CHAN_ALL,    1'b1, CMD_INIT, 16'd8,    4'd1, 1'b1,
      VERDICT_COMPLETE, ERR_NONE},
    '{1'b0, 32'h0,    CHAN_ALL,    1'b1, CMD_PING, 16'hFFFF, 4'd1, 1'b1,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b0, 32'h0,    CHAN_ALL,    1'b0, 8'h00,    16'd0,    4'd1, 1'b1,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b1, ID_A,     ID_A,        1'b0, 8'h00,    16'd0,    4'd8, 1'b0,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b0, 32'h0,    ID_A,        1'b1, CMD_INIT, 16'd471,  4'd1, 1'b1,
      VERDICT_ERROR,    ERR_LENGTH},
    '{1'b0, 32'h0,    ID_A,        1'b0, 8'h00,    16'd0,    4'd1, 1'b1,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b0, 32'h0,    ID_B,        1'b1, CMD_INIT, 16'd5,    4'd1, 1'b1,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b0, 32'h0,    CHAN_ALL,    1'b1, CMD_MSG,  16'd470,  4'd1, 1'b0,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b0, 32'h0,    ID_A,        1'b0, 8'h01,    16'd0,    4'd1, 1'b1,
      VERDICT_ERROR,    ERR_SEQUENCE},
    '{1'b0, 32'h0,    ID_A,        1'b1, 8'h80,    16'd1,    4'd1, 1'b1,
      VERDICT_ERROR,    ERR_COMMAND},
    '{1'b0, 32'h0,    ID_A,        1'b1, 8'hFF,    16'd0,    4'd1, 1'b1,
      VERDICT_ERROR,    ERR_COMMAND},
    '{1'b0, 32'h0,    ID_A,        1'b1, CMD_WINK, 16'd0,    4'd1, 1'b1,
      VERDICT_COMPLETE, ERR_NONE},
    '{1'b0, 32'h0,    ID_A,        1'b1, CMD_PING, 16'd57,   4'd1, 1'b1,
      VERDICT_COMPLETE, ERR_NONE},
    '{1'b0, 32'h0,    ID_A,        1'b1, CMD_INIT, 16'd58,   4'd1, 1'b1,
      VERDICT_WAITING,  ERR_NONE},
    '{1'b0, 32'h0,    ID_A,        1'b0, 8'h00,    16'd0,    4'd2, 1'b0,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b1, 32'h0,    32'h0,       1'b1, CMD_INIT, 16'd0,    4'd1, 1'b0,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b1, CHAN_ALL, 32'h0,       1'b1, CMD_INIT, 16'd0,    4'd1, 1'b1,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b0, 32'h0,    CHAN_ALL,    1'b1, CMD_MSG,  16'h1234, 4'd1, 1'b1,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b1, ID_NEAR_ALL, ID_NEAR_ALL, 1'b0, 8'h00, 16'd0,    4'd1, 1'b0,
      VERDICT_IGNORED,  ERR_NONE},
    '{1'b0, 32'h0,    CHAN_ALL,    1'b0, 8'h01,    16'd0,    4'd1, 1'b0,
      VERDICT_IGNORED,  ERR_NONE}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rpt_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic [8:0]  payload_offset_o;
  logic        verdict_valid_o;
  logic [1:0]  verdict_o;
  logic [1:0]  error_code_o;
  logic [7:0]  message_cmd_o;
  logic [8:0]  message_len_o;

  hid_frame_reassembler_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rpt_byte_i       (rpt_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .payload_offset_o (payload_offset_o),
    .verdict_valid_o  (verdict_valid_o),
    .verdict_o        (verdict_o),
    .error_code_o     (error_code_o),
    .message_cmd_o    (message_cmd_o),
    .message_len_o    (message_len_o)
  );

  // tracked reassembler state, mirrors the block from reset
  logic [31:0] trk_channel_id = CHAN_ALL;
  logic [5:0]  trk_pos = '0;
  logic [31:0] trk_frame_chan = '0;
  disp_e       trk_disp = DISP_IGNORE;
  logic [7:0]  trk_seq = '0;
  logic [7:0]  trk_cmd = '0;
  logic [15:0] trk_len = '0;
  logic [15:0] trk_wptr = '0;

  report_byte_t report_bytes_q [$];
  result_t      pending_results [$];
  report_byte_t cur_byte;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;

  // message planner for the random part
  int          plan_left = 0;
  logic [7:0]  plan_seq = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // expected result of one report byte; advances the tracked state
  function automatic result_t reassemble_byte(input logic [7:0] b);
    result_t r;
    logic    chan_ok;
    logic    bcast;
    r = '0;
    if (trk_pos < POS_TYPE) begin
      trk_frame_chan = (trk_pos == 0) ? {24'd0, b} : {trk_frame_chan[23:0], b};
    end else if (trk_pos == POS_TYPE) begin
      chan_ok = (trk_frame_chan == CHAN_ALL) || (trk_frame_chan == trk_channel_id);
      bcast = (trk_channel_id == CHAN_ALL);
      if (!chan_ok) begin
        trk_disp = DISP_IGNORE;
      end else if (b[TYPE_INIT_BIT]) begin
        trk_seq = '0;
        trk_wptr = '0;
        trk_cmd = b;
        trk_len = '0;
        trk_disp = (bcast && b != CMD_INIT) ? DISP_INIT_QUIET : DISP_INIT_OK;
      end else if (bcast) begin
        trk_disp = DISP_IGNORE;
      end else if (trk_wptr >= trk_len || int'(trk_wptr) + CONT_BYTES > BUF_BYTES) begin
        trk_disp = DISP_IGNORE;
      end else if (b == trk_seq) begin
        trk_seq = trk_seq + 8'd1;
        trk_disp = DISP_CONT;
      end else begin
        trk_disp = DISP_SEQ_ERR;
      end
    end else if (trk_pos == POS_LEN_HI) begin
      if (trk_disp == DISP_INIT_OK || trk_disp == DISP_INIT_QUIET) trk_len = {b, 8'd0};
    end else if (trk_pos == POS_LEN_LO) begin
      if (trk_disp == DISP_INIT_OK || trk_disp == DISP_INIT_QUIET) begin
        trk_len = {trk_len[15:8], b};
        if (trk_disp == DISP_INIT_OK && trk_len > BUF_BYTES) begin
          trk_len = '0;
          trk_disp = DISP_LEN_ERR;
        end
      end
    end

    // data bytes that land in the message buffer
    if (((trk_disp == DISP_INIT_OK || trk_disp == DISP_INIT_QUIET ||
          trk_disp == DISP_LEN_ERR) && trk_pos >= INIT_DATA_START) ||
        (trk_disp == DISP_CONT && trk_pos >= CONT_DATA_START)) begin
      r.payload_valid = 1'b1;
      r.payload_byte = b;
      r.payload_offset = trk_wptr[8:0];
      trk_wptr = trk_wptr + 16'd1;
    end

    // verdict on the last byte of the report
    if (trk_pos == REPORT_BYTES - 1) begin
      r.verdict_valid = 1'b1;
      if (trk_disp == DISP_SEQ_ERR) begin
        r.verdict = VERDICT_ERROR;
        r.error_code = ERR_SEQUENCE;
      end else if (trk_disp == DISP_LEN_ERR) begin
        r.verdict = VERDICT_ERROR;
        r.error_code = ERR_LENGTH;
      end else if (trk_disp == DISP_INIT_OK || trk_disp == DISP_CONT) begin
        if (trk_wptr < trk_len) begin
          r.verdict = VERDICT_WAITING;
        end else begin
          case (trk_cmd)
            CMD_PING, CMD_MSG, CMD_INIT, CMD_WINK: r.verdict = VERDICT_COMPLETE;
            default: begin
              r.verdict = VERDICT_ERROR;
              r.error_code = ERR_COMMAND;
            end
          endcase
        end
      end
      if (r.verdict != VERDICT_IGNORED) begin
        r.message_cmd = trk_cmd;
        r.message_len = (trk_len > 16'd511) ? LEN_SAT : trk_len[8:0];
      end
    end

    trk_pos = (trk_pos == REPORT_BYTES - 1) ? 6'd0 : trk_pos + 6'd1;
    return r;
  endfunction

  // report byte sender; predicts each accepted transfer
  always @(posedge clk_i) begin : tx
    result_t want;
    if (in_valid_i && !in_stall_o) begin
      want = reassemble_byte(cur_byte.data);
      if (cur_byte.typed) begin
        want.verdict = cur_byte.vd;
        want.error_code = cur_byte.ec;
      end
      pending_results.push_back(want);
    end
    if (!in_valid_i || !in_stall_o) begin
      if (report_bytes_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur_byte = report_bytes_q.pop_front();
        rpt_byte_i <= cur_byte.data;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver: checks each transfer, drives stall
  always @(posedge clk_i) begin : rx
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.payload_valid = payload_valid_o;
      got.payload_byte = payload_byte_o;
      got.payload_offset = payload_offset_o;
      got.verdict_valid = verdict_valid_o;
      got.verdict = verdict_e'(verdict_o);
      got.error_code = error_e'(error_code_o);
      got.message_cmd = message_cmd_o;
      got.message_len = message_len_o;
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTED)
          $display("%0t: unexpected result transfer pv=%0d pb=%02h po=%0d vv=%0d vd=%0d",
                   $realtime, got.payload_valid, got.payload_byte, got.payload_offset,
                   got.verdict_valid, got.verdict);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTED) begin
            $write("%0t: mismatch exp pv=%0d pb=%02h po=%0d vv=%0d vd=%0d ec=%0d cmd=%02h len=%0d",
                   $realtime, want.payload_valid, want.payload_byte,
                   want.payload_offset, want.verdict_valid, want.verdict,
                   want.error_code, want.message_cmd, want.message_len);
            $display(" / got pv=%0d pb=%02h po=%0d vv=%0d vd=%0d ec=%0d cmd=%02h len=%0d",
                     got.payload_valid, got.payload_byte, got.payload_offset,
                     got.verdict_valid, got.verdict, got.error_code,
                     got.message_cmd, got.message_len);
          end
        end
      end
    end
    // long hold-off on request, else random stall
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("hid_frame_reassembler_unit verification failed");
    $finish;
  end

  // queue one 64-byte report; a typed verdict rides on its last byte
  task automatic push_report(input logic [31:0] ch, input bit init, input logic [7:0] kind,
                             input logic [15:0] len, input bit typed, input verdict_e vd,
                             input error_e ec);
    report_byte_t it;
    for (int p = 0; p < REPORT_BYTES; p++) begin
      it.data = 8'($urandom);
      if (p < POS_TYPE) it.data = ch[31 - 8*p -: 8];
      else if (p == POS_TYPE) it.data = kind;
      else if (init && p == POS_LEN_HI) it.data = len[15:8];
      else if (init && p == POS_LEN_LO) it.data = len[7:0];
      it.typed = typed && (p == REPORT_BYTES - 1);
      it.vd = vd;
      it.ec = ec;
      report_bytes_q.push_back(it);
    end
  endtask

  // declared length, mostly short messages
  function automatic logic [15:0] pick_msg_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 180));
    if (r < 85) return 16'($urandom_range(181, BUF_BYTES));
    if (r < 92) return 16'd0;
    return 16'($urandom_range(BUF_BYTES + 1, 65535));
  endfunction

  // one random report: well-formed message traffic, broken frames and noise
  task automatic push_random_report();
    int          r;
    logic [31:0] ch;
    bit          init;
    logic [7:0]  kind;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    ch = trk_channel_id;
    if ($urandom_range(0, 9) == 0) ch = CHAN_ALL;
    init = 1'b1;
    kind = CMD_INIT;
    len = pick_msg_len();
    if (trk_channel_id == CHAN_ALL) begin
      if (r < 55) begin
        // init on broadcast, the normal case
      end else if (r < 75) begin
        kind = {1'b1, 7'($urandom)};
      end else if (r < 85) begin
        init = 1'b0;
        kind = {1'b0, 7'($urandom_range(0, 3))};
      end else if (r < 92) begin
        ch = $urandom;
      end else begin
        kind = 8'($urandom);
        init = kind[TYPE_INIT_BIT];
        len = 16'($urandom);
        ch = $urandom;
      end
    end else begin
      if (plan_left > 0 && r < 60) begin
        init = 1'b0;
        kind = plan_seq;
        plan_seq = plan_seq + 8'd1;
        plan_left--;
      end else if (r < 80) begin
        case ($urandom_range(0, 4))
          0: kind = CMD_PING;
          1: kind = CMD_MSG;
          2: kind = CMD_INIT;
          3: kind = CMD_WINK;
          default: kind = {1'b1, 7'($urandom)};
        endcase
        plan_seq = '0;
        plan_left = (len > INIT_DATA_BYTES && len <= BUF_BYTES) ?
                    (int'(len) - INIT_DATA_BYTES + CONT_BYTES - 1) / CONT_BYTES : 0;
      end else if (r < 87) begin
        init = 1'b0;
        kind = {1'b0, 7'(plan_seq + $urandom_range(1, 127))};
      end else if (r < 93) begin
        ch = $urandom;
        kind = 8'($urandom);
        init = kind[TYPE_INIT_BIT];
      end else begin
        kind = 8'($urandom);
        init = kind[TYPE_INIT_BIT];
        len = 16'($urandom);
        if ($urandom_range(0, 1) == 0) ch = $urandom;
      end
    end
    push_report(ch, init, kind, len, 1'b0, VERDICT_IGNORED, ERR_NONE);
  endtask

  // wait until every queued byte has gone through and every result is back
  task automatic settle();
    @(negedge clk_i);
    while (report_bytes_q.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // setup and access cycle on the register port
  task automatic write_channel_id(input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CHANNEL_ID;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    trk_channel_id = value;
  endtask

  // main sequence
  initial begin
    logic [31:0] phase_id;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // scripted header cases, no idling
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].set_id) begin
        settle();
        write_channel_id(SCRIPT[i].id);
      end
      for (int k = 0; k < SCRIPT[i].reps; k++)
        push_report(SCRIPT[i].chan, SCRIPT[i].init, SCRIPT[i].kind + 8'(k), SCRIPT[i].len,
                    SCRIPT[i].typed, SCRIPT[i].vd, SCRIPT[i].ec);
    end

    // random phases, each setting a channel id and an idle and stall pattern
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        0: phase_id = $urandom;
        1: phase_id = 32'h0;
        2: phase_id = CHAN_ALL;
        3: phase_id = $urandom;
        default: phase_id = ID_NEAR_ALL;
      endcase
      write_channel_id(phase_id);
      case (ph)
        1: begin idle_pct <= 68; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 68; end
        3: begin idle_pct <= 10; stall_pct <= 10; end
        default: begin idle_pct <= 0; stall_pct <= 0; end
      endcase
      // last phase: receiver holds off while the sender keeps offering
      if (ph == RANDOM_PHASES - 1) hold_req <= hold_req + 1;
      repeat (REPORTS_PER_PHASE) push_random_report();
    end

    settle();
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("hid_frame_reassembler_unit verification clean");
    end else begin
      $display("hid_frame_reassembler_unit verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/hfr_pkg.sv
rtl/hfr_input_stage.sv
rtl/hfr_frame_tracker.sv
rtl/hfr_result_stage.sv
rtl/hid_frame_reassembler_unit.sv
bench/tb.sv
